// File: rtl/core/hira_pkg.sv
// ----------------------------------------------------------------------------
// hira_pkg
// Shared types and constants of the hashed id range allocator.
// ----------------------------------------------------------------------------
package hira_pkg;

	// mix constants
	localparam logic [63:0] MIX_K0 = 64'h9e3779b185ebca87;
	localparam logic [63:0] MIX_K1 = 64'hc2b2ae3d27d4eb4f;
	localparam logic [63:0] MIX_K2 = 64'h165667b19e3779f9;

	// command codes
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_ALLOC = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_CLEARED = 3'd0;
	localparam logic [2:0] ST_STORED  = 3'd1;
	localparam logic [2:0] ST_DUP     = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_ALLOC   = 3'd4;
	localparam logic [2:0] ST_NOFREE  = 3'd5;

	// configuration register indexes
	localparam logic CFG_BASE_START = 1'b0;
	localparam logic CFG_SLOT_LEN   = 1'b1;

	// sequencer states
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_HASH = 6'b000010,
		S_CAND = 6'b000100,
		S_SCAN = 6'b001000,
		S_DEC  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

endpackage

// File: rtl/core/hashed_id_range_allocator.sv
// ----------------------------------------------------------------------------
// hashed_id_range_allocator
// Range table with clear, load and hashed-probe allocate commands.
// ----------------------------------------------------------------------------
// Allocate makes at most 2^SLOT_BITS probes. Each probe scans the range RAM
// one entry per cycle, and the hash runs through one shared 32x32 multiplier;
// the first probe also hashes the user id. One command at a time; a finished
// result waits in the output register.
// reset: table empty, base_start = 2^29, slot_len = 2^16, no result pending.
module hashed_id_range_allocator
	import hira_pkg::*;
#(
	parameter int MAX_RANGES = 256,
	parameter int SLOT_BITS  = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // range_start, range_len, user_id
	input  logic [1:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // alloc_start, probe_count, zero pad
	output logic [2:0]  m_tuser,  // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_data
);

	localparam int AW   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNTW = $clog2(MAX_RANGES + 1);
	localparam int PW   = SLOT_BITS + 17;
	localparam int CW   = ((PW > 32) ? PW : 32) + 1;

	state_t                 state_q;
	logic [1:0]             func_q;
	logic [31:0]            rs_q, rl_q, uid_q;
	logic [31:0]            base_q;
	logic [16:0]            slen_q;
	logic [CNTW-1:0]        cnt_q, rd_q;
	logic [2:0]             hstep_q;
	logic [1:0]             mstep_q;
	logic [63:0]            opa_q, acc_q, h1_q, h2_q, h_q;
	logic [SLOT_BITS-1:0]   i_q, slot_q;
	logic [CW-1:0]          cand_q;
	logic                   rv_s1;
	logic                   hn_q, hp_q, dup_q;
	logic [31:0]            next_q, prev_q;
	logic [32:0]            pend_q;
	logic [2:0]             rst_q;
	logic [31:0]            rstart_q;
	logic [13:0]            rprobe_q;
	logic                   mv_q;
	logic [2:0]             ms_q;
	logic [31:0]            ma_q;
	logic [13:0]            mp_q;

	logic [63:0]            kc, prep, mres, rd_data, t4;
	logic [31:0]            mx, my, i_ext;
	logic [63:0]            prod;
	logic                   mem_we, mem_re, fin_ok, free;
	logic [CW:0]            cand_end;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = mv_q;
	assign m_tuser   = ms_q;
	assign m_tdata   = {2'b00, mp_q, ma_q};
	assign i_ext     = 32'(i_q);

	// per-step multiplier constant
	always_comb begin
		case (hstep_q)
			3'd1, 3'd3: kc = MIX_K0;
			3'd5:       kc = MIX_K2;
			default:    kc = MIX_K1;
		endcase
	end

	// operand of the current hash step
	assign t4 = {h1_q[45:0], h1_q[63:46]} + {h2_q[56:0], h2_q[63:57]};
	always_comb begin
		case (hstep_q)
			3'd0:    prep = 64'(uid_q);
			3'd1:    prep = h2_q;
			3'd2:    prep = 64'(i_q);
			3'd3:    prep = h1_q;
			3'd4:    prep = t4 ^ (t4 >> 33);
			default: prep = h_q ^ (h_q >> 29);
		endcase
	end

	// one 32x32 partial product per cycle, low 64 bits of the full product
	always_comb begin
		case (mstep_q)
			2'd1:    begin mx = opa_q[31:0];  my = kc[31:0];  end
			2'd2:    begin mx = opa_q[31:0];  my = kc[63:32]; end
			default: begin mx = opa_q[63:32]; my = kc[31:0];  end
		endcase
	end
	assign prod = 64'(mx) * 64'(my);
	assign mres = acc_q + {prod[31:0], 32'b0};

	// candidate check
	assign cand_end = (CW+1)'(cand_q) + (CW+1)'(slen_q);
	assign free = (cand_q[CW-1:32] == '0)
		&& !(hn_q && ((CW+1)'(next_q) < cand_end))
		&& !(hp_q && ((CW+1)'(pend_q) > (CW+1)'(cand_q)));

	assign fin_ok = !mv_q || m_tready;
	assign mem_re = (state_q == S_SCAN) && (rd_q != cnt_q);
	assign mem_we = (state_q == S_DEC) && (func_q == FUNC_LOAD) && !dup_q
		&& (cnt_q < CNTW'(MAX_RANGES));

	hira_ram #(
		.WIDTH (64),
		.DEPTH (MAX_RANGES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({rl_q, rs_q}),
		.re    (mem_re),
		.raddr (rd_q[AW-1:0]),
		.rdata (rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			func_q   <= FUNC_CLEAR;
			rs_q     <= '0;
			rl_q     <= '0;
			uid_q    <= '0;
			base_q   <= 32'h2000_0000;
			slen_q   <= 17'h1_0000;
			cnt_q    <= '0;
			rd_q     <= '0;
			hstep_q  <= '0;
			mstep_q  <= '0;
			opa_q    <= '0;
			acc_q    <= '0;
			h1_q     <= '0;
			h2_q     <= '0;
			h_q      <= '0;
			i_q      <= '0;
			slot_q   <= '0;
			cand_q   <= '0;
			rv_s1    <= 1'b0;
			hn_q     <= 1'b0;
			hp_q     <= 1'b0;
			dup_q    <= 1'b0;
			next_q   <= '0;
			prev_q   <= '0;
			pend_q   <= '0;
			rst_q    <= ST_CLEARED;
			rstart_q <= '0;
			rprobe_q <= '0;
			mv_q     <= 1'b0;
			ms_q     <= ST_CLEARED;
			ma_q     <= '0;
			mp_q     <= '0;
		end else begin
			// output register drains, unless a new result replaces it
			if (mv_q && m_tready && (state_q != S_DONE)) begin
				mv_q <= 1'b0;
			end
			// configuration writes
			if (cfg_valid) begin
				case (cfg_addr)
					CFG_BASE_START: base_q <= cfg_data;
					CFG_SLOT_LEN:   slen_q <= cfg_data[16:0];
					default:        ;
				endcase
			end
			rv_s1 <= mem_re;
			if (mem_re) begin
				rd_q <= rd_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						func_q <= s_tuser;
						rs_q   <= s_tdata[31:0];
						rl_q   <= s_tdata[63:32];
						uid_q  <= s_tdata[95:64];
						rd_q   <= '0;
						hn_q   <= 1'b0;
						hp_q   <= 1'b0;
						dup_q  <= 1'b0;
						case (s_tuser)
							FUNC_CLEAR: begin
								cnt_q   <= '0;
								rst_q   <= ST_CLEARED;
								state_q <= S_DONE;
							end
							FUNC_LOAD: state_q <= S_SCAN;
							FUNC_ALLOC: begin
								i_q     <= '0;
								hstep_q <= '0;
								mstep_q <= '0;
								state_q <= S_HASH;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_HASH: begin
					mstep_q <= mstep_q + 1'b1;
					case (mstep_q)
						2'd0: begin
							opa_q <= prep;
							acc_q <= '0;
						end
						2'd1: acc_q <= prod;
						2'd2: acc_q <= mres;
						default: begin
							hstep_q <= hstep_q + 1'b1;
							case (hstep_q)
								3'd0: h2_q <= ((MIX_K1 + mres) << 31)
									| ((MIX_K1 + mres) >> 33);
								3'd1: h2_q <= mres;
								3'd2: h1_q <= ((mres - MIX_K0) << 31)
									| ((mres - MIX_K0) >> 33);
								3'd3: h1_q <= mres;
								3'd4: h_q <= mres;
								default: begin
									slot_q  <= mres[SLOT_BITS-1:0]
										^ mres[SLOT_BITS+31:32];
									state_q <= S_CAND;
								end
							endcase
						end
					endcase
				end
				S_CAND: begin
					cand_q  <= CW'(slot_q) * CW'(slen_q) + CW'(base_q);
					rd_q    <= '0;
					hn_q    <= 1'b0;
					hp_q    <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// fold in one stored entry per cycle
					if (rv_s1) begin
						if (rd_data[31:0] == rs_q) begin
							dup_q <= 1'b1;
						end
						if (rd_data[31:0] >= cand_q[31:0]) begin
							if (!hn_q || rd_data[31:0] < next_q) begin
								next_q <= rd_data[31:0];
								hn_q   <= 1'b1;
							end
						end else if (!hp_q || rd_data[31:0] > prev_q) begin
							prev_q <= rd_data[31:0];
							pend_q <= 33'(rd_data[31:0]) + 33'(rd_data[63:32]);
							hp_q   <= 1'b1;
						end
					end
					if ((rd_q == cnt_q) && !rv_s1) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (func_q == FUNC_LOAD) begin
						if (dup_q) begin
							rst_q <= ST_DUP;
						end else if (cnt_q >= CNTW'(MAX_RANGES)) begin
							rst_q <= ST_FULL;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							rst_q <= ST_STORED;
						end
						rstart_q <= '0;
						rprobe_q <= '0;
						state_q  <= S_DONE;
					end else if (free) begin
						rst_q    <= ST_ALLOC;
						rstart_q <= cand_q[31:0];
						rprobe_q <= i_ext[13:0];
						state_q  <= S_DONE;
					end else if (i_q == '1) begin
						rst_q    <= ST_NOFREE;
						rstart_q <= '0;
						rprobe_q <= '0;
						state_q  <= S_DONE;
					end else begin
						// next probe, user hash half is kept
						i_q     <= i_q + 1'b1;
						hstep_q <= 3'd2;
						mstep_q <= '0;
						state_q <= S_HASH;
					end
				end
				S_DONE: begin
					if (fin_ok) begin
						mv_q    <= 1'b1;
						ms_q    <= rst_q;
						ma_q    <= (rst_q == ST_ALLOC) ? rstart_q : 32'd0;
						mp_q    <= (rst_q == ST_ALLOC) ? rprobe_q : 14'd0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// table fill never passes its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_RANGES))
		else $error("entry count beyond table depth");

	// table writes only come from a load that found no duplicate
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (func_q == FUNC_LOAD) && !dup_q)
		else $error("table write outside a load");

	// a scan read returns data in the next cycle while still scanning
	a_read_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (state_q == S_SCAN) && rv_s1)
		else $error("scan read lost");

	// a result is presented only from the finish state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mv_q) |-> $past(state_q) == S_DONE)
		else $error("result without finished command");
`endif

endmodule

// File: rtl/core/hira_ram.sv
// ----------------------------------------------------------------------------
// hira_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hira_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hashed id range allocator. Drives clear, load,
// allocate and no-op commands over the stream input with random idling. A
// local model of the range table and the probe hash predicts each result, and
// the results are compared field by field in arrival order. The bench runs
// several register settings, including the extremes.
// ----------------------------------------------------------------------------
module tb
	import hira_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANGES  = 256;
	localparam int N_SLOTBIT = 14;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] start;
		logic [13:0] probes;
	} alloc_result_t;

	// table model, probe hash and queue of predicted results
	class alloc_scoreboard;
		logic [31:0]   base;
		logic [16:0]   len;
		logic [31:0]   starts[N_RANGES];
		logic [31:0]   lengths[N_RANGES];
		int            count;
		alloc_result_t pending[$];
		int            errors;

		function new();
			base = 32'h2000_0000;
			len = 17'h10000;
			count = 0;
			errors = 0;
		endfunction

		function logic [63:0] rotl(logic [63:0] x, int r);
			return (x << r) | (x >> (64 - r));
		endfunction

		function logic [63:0] mix(logic [63:0] acc, logic [63:0] v);
			logic [63:0] a;
			a = acc + v * MIX_K1;
			a = rotl(a, 31);
			return a * MIX_K0;
		endfunction

		function logic [63:0] slot_hash(logic [63:0] a, logic [63:0] b);
			logic [63:0] h;
			h = rotl(mix(64'd0 - MIX_K0, a), 18) + rotl(mix(MIX_K1, b), 7);
			h = h ^ (h >> 33);
			h = h * MIX_K1;
			h = h ^ (h >> 29);
			h = h * MIX_K2;
			h = h ^ (h >> 32);
			return h;
		endfunction

		function bit slot_free(logic [63:0] cand);
			bit          got_next;
			bit          got_prev;
			logic [63:0] next_s;
			logic [63:0] prev_s;
			logic [63:0] prev_end;
			logic [63:0] s;
			got_next = 0;
			got_prev = 0;
			next_s = 0;
			prev_s = 0;
			prev_end = 0;
			if (cand > 64'hFFFF_FFFF)
				return 0;
			for (int k = 0; k < count; k++) begin
				s = {32'd0, starts[k]};
				if (s >= cand) begin
					if (!got_next || s < next_s) begin
						next_s = s;
						got_next = 1;
					end
				end else if (!got_prev || s > prev_s) begin
					prev_s = s;
					prev_end = s + {32'd0, lengths[k]};
					got_prev = 1;
				end
			end
			if (got_next && next_s < cand + {47'd0, len})
				return 0;
			if (got_prev && prev_end > cand)
				return 0;
			return 1;
		endfunction

		function void write_reg(logic addr, logic [31:0] data);
			if (addr == CFG_BASE_START)
				base = data;
			else
				len = data[16:0];
		endfunction

		// accepted command: update table and predict its result
		function void note_command(logic [1:0] func, logic [31:0] rs, logic [31:0] rl,
				logic [31:0] uid);
			alloc_result_t r;
			bit            dup;
			logic [63:0]   cand;
			r.status = ST_CLEARED;
			r.start = 0;
			r.probes = 0;
			if (func == FUNC_NONE)
				return;
			if (func == FUNC_CLEAR) begin
				count = 0;
			end else if (func == FUNC_LOAD) begin
				dup = 0;
				for (int k = 0; k < count; k++)
					if (starts[k] == rs)
						dup = 1;
				if (dup) begin
					r.status = ST_DUP;
				end else if (count >= N_RANGES) begin
					r.status = ST_FULL;
				end else begin
					starts[count] = rs;
					lengths[count] = rl;
					count++;
					r.status = ST_STORED;
				end
			end else begin
				r.status = ST_NOFREE;
				for (int i = 0; i < (1 << N_SLOTBIT); i++) begin
					cand = (slot_hash(i, {32'd0, uid}) & ((64'd1 << N_SLOTBIT) - 1))
						* {47'd0, len} + {32'd0, base};
					if (slot_free(cand)) begin
						r.status = ST_ALLOC;
						r.start = cand[31:0];
						r.probes = i[13:0];
						break;
					end
				end
			end
			pending.push_back(r);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h expected %h", what, got, want);
			errors++;
		endtask

		// accepted result: compare against oldest prediction
		task check_result(logic [2:0] status, logic [31:0] start, logic [13:0] probes);
			alloc_result_t r;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", {29'd0, status}, 0);
				return;
			end
			r = pending.pop_front();
			if (status !== r.status)
				report_mismatch("status", {29'd0, status}, {29'd0, r.status});
			if (start !== r.start)
				report_mismatch("alloc_start", start, r.start);
			if (probes !== r.probes)
				report_mismatch("probe_count", {18'd0, probes}, {18'd0, r.probes});
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;  // range_start, range_len, user_id
	logic [1:0]  s_tuser;  // func
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;  // alloc_start, probe_count, zero pad
	logic [2:0]  m_tuser;  // status
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_addr;
	logic [31:0] cfg_data;

	alloc_scoreboard sb;
	bit     rx_hold;
	bit     no_gaps;
	longint cycles;

	hashed_id_range_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	// clock
	initial clk = 0;
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: random stalls, one long hold on request
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				m_tready <= 0;
				repeat (3000) @(posedge clk);
				rx_hold = 0;
			end
			m_tready <= (pick_gap() == 0);
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata[31:0], m_tdata[45:32]);
		end
	end

	// one command transaction, then a random gap
	task send_cmd(logic [1:0] func, logic [31:0] rs, logic [31:0] rl, logic [31:0] uid);
		int gap;
		s_tvalid <= 1;
		s_tuser <= func;
		s_tdata <= {uid, rl, rs};
		do @(posedge clk); while (!s_tready);
		sb.note_command(func, rs, rl, uid);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task wait_results();
		s_tvalid <= 0;
		while (sb.pending.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task write_cfg(logic addr, logic [31:0] data);
		cfg_valid <= 1;
		cfg_addr <= addr;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.write_reg(addr, data);
	endtask

	// random load, mostly inside the allocatable region so probes collide
	task random_load();
		int          r;
		logic [31:0] rs;
		logic [31:0] rl;
		r = $urandom_range(0, 99);
		rl = $urandom_range(1, 2 * sb.len + 1);
		rs = sb.base + $urandom_range(0, (1 << N_SLOTBIT) - 1) * sb.len
			+ $urandom_range(0, 3);
		if (r < 10 && sb.count > 0) begin
			rs = sb.starts[$urandom_range(0, sb.count - 1)];
		end else if (r < 20) begin
			rs = 32'hF000_0000 | $urandom;
			rl = $urandom;
		end else if (r < 40) begin
			rs = $urandom;
			rl = $urandom & 32'hFFFF;
			if (rs < sb.base)
				rl = $urandom_range(0, 255);
		end
		send_cmd(FUNC_LOAD, rs, rl, $urandom);
	endtask

	task random_phase(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (i % 30 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if (r < 3 || sb.count > 30)
				send_cmd(FUNC_CLEAR, $urandom, $urandom, $urandom);
			else if (r < 45)
				random_load();
			else if (r < 50)
				send_cmd(FUNC_NONE, $urandom, $urandom, $urandom);
			else
				send_cmd(FUNC_ALLOC, $urandom, $urandom, $urandom);
		end
		no_gaps = 0;
	endtask

	initial begin
		sb = new();
		rx_hold = 0;
		no_gaps = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = FUNC_CLEAR;
		cfg_valid = 0;
		cfg_addr = CFG_BASE_START;
		cfg_data = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings, edge values, duplicates, no free slot
		send_cmd(FUNC_CLEAR, 0, 0, 0);
		send_cmd(FUNC_ALLOC, 0, 0, 0);
		send_cmd(FUNC_LOAD, 32'h2000_0000, 32'h0001_0000, 0);
		send_cmd(FUNC_LOAD, 32'h2000_0000, 32'h5, 32'hFFFF_FFFF);
		send_cmd(FUNC_LOAD, 0, 0, 0);
		send_cmd(FUNC_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(FUNC_ALLOC, 0, 0, 32'hFFFF_FFFF);
		send_cmd(FUNC_ALLOC, 0, 0, 32'h0000_0001);
		send_cmd(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(FUNC_LOAD, 0, 32'hFFFF_FFFF, 0);
		send_cmd(FUNC_ALLOC, 0, 0, 32'h1234_5678);
		send_cmd(FUNC_CLEAR, 0, 0, 0);

		// long receiver hold while commands keep coming
		rx_hold = 1;
		random_phase(50);

		// fill the table to the limit
		wait_results();
		for (int i = 0; i < N_RANGES; i++)
			send_cmd(FUNC_LOAD, i * 32'h0100_0000 + 32'h10, 32'h100, 0);
		send_cmd(FUNC_LOAD, 32'h0000_0001, 32'h1, 0);
		send_cmd(FUNC_LOAD, 32'h0300_0010, 32'h1, 0);
		send_cmd(FUNC_ALLOC, 0, 0, $urandom);
		send_cmd(FUNC_ALLOC, 0, 0, $urandom);
		send_cmd(FUNC_CLEAR, 0, 0, 0);

		// register settings, extremes among them
		wait_results();
		write_cfg(CFG_BASE_START, 32'h0);
		write_cfg(CFG_SLOT_LEN, 32'h1);
		random_phase(50);
		wait_results();
		write_cfg(CFG_BASE_START, 32'h8000_0000);
		write_cfg(CFG_SLOT_LEN, 32'h10000);
		random_phase(50);
		wait_results();
		write_cfg(CFG_BASE_START, 32'h1234_5678);
		write_cfg(CFG_SLOT_LEN, 32'h0);
		send_cmd(FUNC_CLEAR, 0, 0, 0);
		random_phase(40);
		wait_results();
		write_cfg(CFG_BASE_START, 32'h0);
		write_cfg(CFG_SLOT_LEN, 32'h1FFFF);
		random_phase(50);
		wait_results();
		write_cfg(CFG_BASE_START, 32'hF000_0000);
		write_cfg(CFG_SLOT_LEN, 32'h10000);
		send_cmd(FUNC_CLEAR, 0, 0, 0);
		random_phase(40);
		wait_results();
		write_cfg(CFG_BASE_START, 32'h2000_0000);
		write_cfg(CFG_SLOT_LEN, 32'h8000);
		random_phase(50);

		wait_results();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
rtl/core/hira_pkg.sv
rtl/core/hira_ram.sv
rtl/core/hashed_id_range_allocator.sv
dv/tb.sv
